// ===== rtl/core/ris_pkg.sv =====
// Package for the record insertion sorter: sizes, field widths and the
// record and control structs shared by the sorting cells and the top level.
// No dependencies.
package ris_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_BITS    = 24;
  localparam int TAG_BITS    = 16;

  localparam int IN_KEY_W    = 24;
  localparam int IN_TAG_W    = 16;
  localparam int OUT_RANK_W  = 7;
  localparam int OUT_KEY_W   = 24;
  localparam int OUT_TAG_W   = 16;
  localparam int TOTAL_W     = 30;
  localparam int SUM_W       = 33;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 80;

  localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'((64'd1 << TOTAL_W) - 64'd1);

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic                ins_en;
    logic                pop;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } ctl_t;

endpackage

// ===== rtl/core/ris_cell.sv =====
// One sorting cell: holds a single record, compares it with the broadcast
// record, and shifts toward its right neighbor on insert or left on pop.
// Depends on ris_pkg.
module ris_cell
  import ris_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  rec_t left_rec,
  input  logic left_gt,
  input  rec_t right_rec,
  output rec_t rec,
  output logic gt
);

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  assign gt  = valid_r && (key_r > ctl.key);
  assign rec = '{valid: valid_r, key: key_r, tag: tag_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctl.ins_en) begin
      if (left_gt) begin
        valid_nxt = left_rec.valid;
        key_nxt   = left_rec.key;
        tag_nxt   = left_rec.tag;
      end else if (left_rec.valid && (gt || !valid_r)) begin
        valid_nxt = 1'b1;
        key_nxt   = ctl.key;
        tag_nxt   = ctl.tag;
      end
    end else if (ctl.pop) begin
      valid_nxt = right_rec.valid;
      key_nxt   = right_rec.key;
      tag_nxt   = right_rec.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule

// ===== rtl/core/record_insertion_sorter.sv =====
// Top level of the record insertion sorter: a chain of sorting cells plus
// the emission counters. Depends on ris_pkg and ris_cell.
//
// Usage:
//   in_*  : one record per transaction, key and tag in in_tdata, in_tlast
//           marks the last record of a set.
//   out_* : the sorted set, one record per transaction from rank 1 upward,
//           out_tlast on the last one, out_tuser set if records were dropped.
// Throughput: one record per cycle is accepted while a set is collected;
//   every cell compares with the new record and shifts in the same cycle.
// After the last record of a set is accepted, the first result appears in the
//   next cycle; results then leave at one per cycle while out_tready is high,
//   taken from the head cell while the chain shifts toward it.
// While a set is being emitted in_tready is low. A stall on out_tready
//   holds the head record and the counters; nothing is lost.
// Capacity is MAX_RECORDS; a record arriving at a full chain is dropped
//   and flags the set. Reset empties the chain and clears all flags.
module record_insertion_sorter
  import ris_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_population[23:0], payload_tag[39:24]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rank[6:0], sorted_key[30:7], sorted_tag[46:31], running_total[76:47], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // overflowed
  output logic                  out_tuser,
  output logic                  out_tlast
);

  rec_t recs [MAX_RECORDS];
  logic gts  [MAX_RECORDS];
  ctl_t ctl;

  logic             emit_r, emit_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] rank_r, rank_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic             in_acc, out_acc, full;
  logic [SUM_W-1:0] sum;
  logic [TOTAL_W-1:0] total_sat;

  assign full      = recs[MAX_RECORDS-1].valid;
  assign in_tready = !emit_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = emit_r && recs[0].valid;
  assign out_acc   = out_tvalid && out_tready;

  assign ctl.ins_en = in_acc && !full;
  assign ctl.pop    = out_acc;
  assign ctl.key    = KEY_BITS'(in_tdata[IN_KEY_W-1:0]);
  assign ctl.tag    = TAG_BITS'(in_tdata[IN_KEY_W +: IN_TAG_W]);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
      rec_t lrec, rrec;
      logic lgt;
      if (gi == 0) begin : g_head
        assign lrec = '{valid: 1'b1, key: '0, tag: '0};
        assign lgt  = 1'b0;
      end else begin : g_body
        assign lrec = recs[gi-1];
        assign lgt  = gts[gi-1];
      end
      if (gi == MAX_RECORDS - 1) begin : g_tail
        assign rrec = '{valid: 1'b0, key: '0, tag: '0};
      end else begin : g_mid
        assign rrec = recs[gi+1];
      end
      ris_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_rec  (lrec),
        .left_gt   (lgt),
        .right_rec (rrec),
        .rec       (recs[gi]),
        .gt        (gts[gi])
      );
    end
  endgenerate

  assign sum       = SUM_W'(total_r) + SUM_W'(recs[0].key);
  assign total_sat = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];

  assign out_tlast = !recs[1].valid;
  assign out_tuser = drop_r;
  assign out_tdata = {3'b000, total_sat, OUT_TAG_W'(recs[0].tag),
                      OUT_KEY_W'(recs[0].key), OUT_RANK_W'(rank_r)};

  always_comb begin
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    rank_nxt  = rank_r;
    total_nxt = total_r;
    if (in_acc) begin
      if (full) begin
        drop_nxt = 1'b1;
      end
      if (in_tlast) begin
        emit_nxt = 1'b1;
      end
    end
    if (emit_r && !recs[0].valid) begin
      emit_nxt = 1'b0;
      drop_nxt = 1'b0;
    end
    if (out_acc) begin
      rank_nxt  = rank_r + CNT_W'(1);
      total_nxt = total_sat;
      if (out_tlast) begin
        emit_nxt  = 1'b0;
        drop_nxt  = 1'b0;
        rank_nxt  = CNT_W'(1);
        total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r  <= 1'b0;
      drop_r  <= 1'b0;
      rank_r  <= CNT_W'(1);
      total_r <= '0;
    end else begin
      emit_r  <= emit_nxt;
      drop_r  <= drop_nxt;
      rank_r  <= rank_nxt;
      total_r <= total_nxt;
    end
  end

  a_final_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (emit_r && recs[0].valid))
    else $error("final record did not start emission");

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> drop_r)
    else $error("record dropped at full chain without flag");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (!recs[0].valid && !emit_r && !drop_r))
    else $error("chain not empty after last result");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    recs[1].valid |-> (recs[0].valid && (recs[0].key <= recs[1].key)))
    else $error("head cells out of order");

endmodule

// ===== verif/tb_record_insertion_sorter.sv =====
// Testbench for record_insertion_sorter: drives keyed records in sets over the
// input stream and checks every sorted result against a stable-insertion predictor.
// Depends on ris_pkg and the record_insertion_sorter RTL.
`timescale 1ns / 100ps

module tb_record_insertion_sorter;
  import ris_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_GAP       = 13;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 70;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [OUT_RANK_W-1:0] rank;
    logic [OUT_KEY_W-1:0]  key;
    logic [OUT_TAG_W-1:0]  tag;
    logic [TOTAL_W-1:0]    total;
    logic                  ovf;
    logic                  eor;
  } sorted_rec_t;

  typedef struct packed {
    logic [IN_KEY_W-1:0] key;
    logic [IN_TAG_W-1:0] tag;
    logic                last;
    logic                typed;
    sorted_rec_t         res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  stim_row_t   row_q[$];
  sorted_rec_t expected_recs[$];

  logic [KEY_BITS-1:0] held_key[MAX_RECORDS];
  logic [TAG_BITS-1:0] held_tag[MAX_RECORDS];
  int                  held_count = 0;
  logic                drop_seen = 1'b0;

  int mismatch_count = 0;
  int results_taken  = 0;
  int cycle_count    = 0;

  stim_row_t directed_rows[19] = '{
    '{24'h000000, 16'h0000, 1'b1, 1'b1, '{7'd1, 24'h000000, 16'h0000, 30'h0, 1'b0, 1'b1}},
    '{24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1,
      '{7'd1, 24'hFFFFFF, 16'hFFFF, 30'h0FFFFFF, 1'b0, 1'b1}},
    '{24'h123456, 16'hBEEF, 1'b1, 1'b1,
      '{7'd1, 24'h123456, 16'hBEEF, 30'h0123456, 1'b0, 1'b1}},
    '{24'd300, 16'hA001, 1'b0, 1'b0, '0},
    '{24'd200, 16'hA002, 1'b0, 1'b0, '0},
    '{24'd100, 16'hA003, 1'b1, 1'b0, '0},
    '{24'd7, 16'hB001, 1'b0, 1'b0, '0},
    '{24'd7, 16'hB002, 1'b0, 1'b0, '0},
    '{24'd3, 16'hB003, 1'b0, 1'b0, '0},
    '{24'd7, 16'hB004, 1'b0, 1'b0, '0},
    '{24'd7, 16'hB005, 1'b1, 1'b0, '0},
    '{24'hFFFFFF, 16'h5555, 1'b0, 1'b0, '0},
    '{24'h000000, 16'hAAAA, 1'b0, 1'b0, '0},
    '{24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    '{24'h000000, 16'h0000, 1'b0, 1'b0, '0},
    '{24'h800000, 16'h8000, 1'b1, 1'b0, '0},
    '{24'h555555, 16'h1234, 1'b0, 1'b0, '0},
    '{24'hAAAAAA, 16'h4321, 1'b0, 1'b0, '0},
    '{24'h000001, 16'h0001, 1'b1, 1'b0, '0}
  };

  record_insertion_sorter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[record_insertion_sorter] ERROR");
      $finish;
    end
  end

  task automatic insert_and_emit(input logic [KEY_BITS-1:0] key,
                                 input logic [TAG_BITS-1:0] tag,
                                 input logic last, input stim_row_t row);
    int               pos;
    logic [SUM_W-1:0] sum;
    sorted_rec_t      rec;
    if (held_count < MAX_RECORDS) begin
      pos = held_count;
      while (pos > 0 && held_key[pos-1] > key) begin
        held_key[pos] = held_key[pos-1];
        held_tag[pos] = held_tag[pos-1];
        pos--;
      end
      held_key[pos] = key;
      held_tag[pos] = tag;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (last) begin
      sum = '0;
      for (int i = 0; i < held_count; i++) begin
        sum = sum + SUM_W'(held_key[i]);
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        rec.rank  = OUT_RANK_W'(i + 1);
        rec.key   = held_key[i];
        rec.tag   = held_tag[i];
        rec.total = sum[TOTAL_W-1:0];
        rec.ovf   = drop_seen;
        rec.eor   = (i + 1 == held_count);
        expected_recs.push_back(row.typed ? row.res : rec);
      end
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  task automatic check_result(input sorted_rec_t got);
    sorted_rec_t want;
    if (expected_recs.size() == 0) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("unexpected result: rank=%0d key=%h tag=%h total=%h ovf=%b last=%b",
                 got.rank, got.key, got.tag, got.total, got.ovf, got.eor);
      mismatch_count++;
    end else begin
      want = expected_recs.pop_front();
      if (got.rank !== want.rank || got.key !== want.key || got.tag !== want.tag ||
          got.total !== want.total || got.ovf !== want.ovf || got.eor !== want.eor) begin
        if (mismatch_count < REPORT_LIMIT)
          $display({"mismatch: exp rank=%0d key=%h tag=%h total=%h ovf=%b last=%b",
                    " / got rank=%0d key=%h tag=%h total=%h ovf=%b last=%b"},
                   want.rank, want.key, want.tag, want.total, want.ovf, want.eor,
                   got.rank, got.key, got.tag, got.total, got.ovf, got.eor);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        insert_and_emit(in_tdata[IN_KEY_W-1:0], in_tdata[IN_KEY_W +: IN_TAG_W], in_tlast,
                        (row_q.size() != 0) ? row_q.pop_front() : stim_row_t'('0));
      if (out_tvalid && out_tready) begin
        check_result(sorted_rec_t'({out_tdata[6:0], out_tdata[30:7], out_tdata[46:31],
                                    out_tdata[76:47], out_tuser, out_tlast}));
        results_taken++;
      end
    end
  end

  task automatic drive_record(input stim_row_t row, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.tag, row.key};
    in_tlast  <= row.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : receiver
    int gap;
    bit rx_burst;
    bit hold_done;
    rx_burst  = 1'b0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int        sent;
    int        set_idx;
    int        set_len;
    int        key_mode;
    bit        tx_burst;
    stim_row_t row;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row_q.push_back(directed_rows[i]);
      drive_record(directed_rows[i], $urandom_range(0, MAX_GAP));
    end

    // cover the capacity edge first: overfull with final dropped, exactly full, overfull
    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      case (set_idx)
        0:       set_len = MAX_RECORDS + 1;
        1:       set_len = MAX_RECORDS;
        2:       set_len = MAX_RECORDS + 3;
        default: set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(1, 10);
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        key_mode = $urandom_range(0, 3);
        case (key_mode)
          0:       row.key = IN_KEY_W'($urandom_range(0, 7));
          1:       row.key = IN_KEY_W'($urandom);
          2:       row.key = $urandom_range(0, 1) ? {IN_KEY_W{1'b1}} : '0;
          default: row.key = IN_KEY_W'($urandom_range(0, 255));
        endcase
        row.tag   = IN_TAG_W'($urandom);
        row.last  = (k == set_len - 1);
        row.typed = 1'b0;
        row.res   = '0;
        row_q.push_back(row);
        drive_record(row, tx_burst ? 0 : $urandom_range(0, MAX_GAP));
        sent++;
      end
      set_idx++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[record_insertion_sorter] OK");
    end else begin
      $display("[record_insertion_sorter] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ris_pkg.sv
rtl/core/ris_cell.sv
rtl/core/record_insertion_sorter.sv
verif/tb_record_insertion_sorter.sv
